>>> rtl/core/led_pkg.sv
`timescale 1ns / 1ps
// led_pkg: widths, constants and beat/struct types of the local extrema detector
// no dependencies; used by led_lane, led_merge and local_extrema_detector_core

package led_pkg;

  localparam int AXES        = 3;
  localparam int VALUE_WIDTH = 32;
  localparam int TIME_WIDTH  = 32;
  localparam int COUNT_WIDTH = 32;
  localparam int STEP_WIDTH  = 31;
  localparam int AXIS_WIDTH  = 2;
  localparam int GROUP_DEPTH = 4;

  localparam logic [COUNT_WIDTH-1:0] COUNT_RESET = COUNT_WIDTH'(2);
  localparam logic [STEP_WIDTH-1:0]  STEP_RESET  = STEP_WIDTH'(1);
  localparam logic [1:0]             PRIME_DONE  = 2'd2;

  typedef struct packed {
    logic [TIME_WIDTH-1:0]         sample_time;
    logic signed [VALUE_WIDTH-1:0] pos_x;
    logic signed [VALUE_WIDTH-1:0] pos_y;
    logic signed [VALUE_WIDTH-1:0] pos_z;
  } led_sample_t;

  typedef struct packed {
    logic [COUNT_WIDTH-1:0]        sample_number;
    logic [TIME_WIDTH-1:0]         extremum_time;
    logic signed [VALUE_WIDTH-1:0] extremum_value;
    logic [AXIS_WIDTH-1:0]         axis;
    logic                          is_maximum;
    logic                          last_of_item;
  } led_report_t;

  typedef struct packed {
    logic hit;
    logic is_max;
  } led_lane_stat_t;

  // all reports caused by one sample, one slot per axis
  typedef struct packed {
    logic [COUNT_WIDTH-1:0]            sample_number;
    logic [TIME_WIDTH-1:0]             extremum_time;
    logic [AXES-1:0][VALUE_WIDTH-1:0]  value;
    logic [AXES-1:0]                   hit;
    logic [AXES-1:0]                   is_max;
  } led_group_t;

endpackage

>>> rtl/core/led_lane.sv
`timescale 1ns / 1ps
// led_lane: one axis of the detector, three-point window, extremum test and holdoff
// depends on led_pkg

module led_lane (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  shift,
  input  logic                                  judge,
  input  logic signed [led_pkg::VALUE_WIDTH-1:0] cur,
  input  logic [led_pkg::TIME_WIDTH-1:0]         prev_time,
  input  logic [led_pkg::STEP_WIDTH-1:0]         step,
  output led_pkg::led_lane_stat_t                stat,
  output logic signed [led_pkg::VALUE_WIDTH-1:0] mid_value
);
  import led_pkg::*;

  logic signed [VALUE_WIDTH-1:0] prev_pos;
  logic signed [VALUE_WIDTH-1:0] before_prev_pos;
  logic [TIME_WIDTH-1:0]         last_time;
  logic                          seen;
  logic [TIME_WIDTH:0]           diff;
  logic                          hold_ok;
  logic                          is_max;
  logic                          is_min;

  always_comb begin
    is_max  = (before_prev_pos <= prev_pos) && (cur <= prev_pos);
    is_min  = (before_prev_pos >= prev_pos) && (cur >= prev_pos);
    // sign bit of the wide difference catches time going backwards
    diff    = {1'b0, prev_time} - {1'b0, last_time};
    hold_ok = !seen || (!diff[TIME_WIDTH] && (diff[TIME_WIDTH-1:0] > {step, 1'b0}));
    stat.hit    = (is_max || is_min) && hold_ok;
    stat.is_max = is_max;
  end

  assign mid_value = prev_pos;

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_pos        <= '0;
      before_prev_pos <= '0;
      last_time       <= '0;
      seen            <= 1'b0;
    end else begin
      if (shift) begin
        before_prev_pos <= prev_pos;
        prev_pos        <= cur;
      end
      if (judge && stat.hit) begin
        last_time <= prev_time;
        seen      <= 1'b1;
      end
    end
  end

endmodule

>>> rtl/core/led_merge.sv
`timescale 1ns / 1ps
// led_merge: queue of per-sample report groups and the output stage that
// sends their reports one beat at a time in axis order; depends on led_pkg

module led_merge #(
  parameter int DEPTH = led_pkg::GROUP_DEPTH
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  led_pkg::led_group_t  push_group,
  output logic                 full,
  output logic                 report_valid,
  input  logic                 report_stall,
  output led_pkg::led_report_t report
);
  import led_pkg::*;

  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  led_group_t            fifo [DEPTH];
  logic [IDX_W-1:0]      wr_ptr;
  logic [IDX_W-1:0]      rd_ptr;
  logic [CNT_W-1:0]      count;
  logic [CNT_W-1:0]      count_next;
  led_group_t            head;
  logic                  head_valid;
  logic [AXES-1:0]       done;
  logic [AXES-1:0]       remaining;
  logic [AXES-1:0]       pick;
  logic [AXIS_WIDTH-1:0] pick_idx;
  logic                  found;
  logic                  is_last;
  logic                  load;
  logic                  pop;

  function automatic logic [IDX_W-1:0] ptr_inc(input logic [IDX_W-1:0] p);
    return (p == IDX_W'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_comb begin
    head       = fifo[rd_ptr];
    head_valid = (count != '0);
    remaining  = head.hit & ~done;
    pick       = '0;
    pick_idx   = '0;
    found      = 1'b0;
    // lowest pending axis goes first
    for (int a = 0; a < AXES; a++) begin
      if (remaining[a] && !found) begin
        pick[a]  = 1'b1;
        pick_idx = AXIS_WIDTH'(a);
        found    = 1'b1;
      end
    end
    is_last = ((remaining & ~pick) == '0);
    load    = head_valid && (!report_valid || !report_stall);
    pop     = load && is_last;
    full    = (count == CNT_W'(DEPTH));
    count_next = count;
    if (push && !pop) begin
      count_next = count + 1'b1;
    end else if (pop && !push) begin
      count_next = count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      fifo[wr_ptr] <= push_group;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr       <= '0;
      rd_ptr       <= '0;
      count        <= '0;
      done         <= '0;
      report_valid <= 1'b0;
    end else begin
      count <= count_next;
      if (push) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      if (load) begin
        done         <= is_last ? '0 : (done | pick);
        report_valid <= 1'b1;
      end else if (!report_stall) begin
        report_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      report.sample_number  <= head.sample_number;
      report.extremum_time  <= head.extremum_time;
      report.extremum_value <= head.value[pick_idx];
      report.axis           <= pick_idx;
      report.is_maximum     <= head.is_max[pick_idx];
      report.last_of_item   <= is_last;
    end
  end

endmodule

>>> rtl/core/local_extrema_detector_core.sv
`timescale 1ns / 1ps
// Local extrema detector: one sample beat per clock enters while the group queue
// has room; every axis lane tests its middle sample in the accept cycle, and an
// item yields one output beat per report, sent one report per cycle from the output
// register while report_stall is low. Throughput is one sample per cycle as long as
// reports average at most one per sample and the output is not stalled; GROUP_DEPTH
// samples with reports can be queued before sample_stall rises. A report passes
// through the group queue and then the output register after its sample is
// accepted. Depends on led_pkg, led_lane and led_merge.

module local_extrema_detector_core #(
  parameter int GROUP_DEPTH = led_pkg::GROUP_DEPTH
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              step_wr_en,
  input  logic [led_pkg::STEP_WIDTH-1:0]    step_wr_data,
  input  logic                              sample_valid,
  output logic                              sample_stall,
  input  led_pkg::led_sample_t              sample,
  output logic                              report_valid,
  input  logic                              report_stall,
  output led_pkg::led_report_t              report
);
  import led_pkg::*;

  logic [STEP_WIDTH-1:0]         step;
  logic [TIME_WIDTH-1:0]         prev_time;
  logic [1:0]                    primed;
  logic [COUNT_WIDTH-1:0]        counter;
  logic [COUNT_WIDTH-1:0]        counter_next;
  logic                          accept;
  logic                          judge;
  logic                          push;
  logic                          full;
  logic signed [VALUE_WIDTH-1:0] cur [AXES];
  logic signed [VALUE_WIDTH-1:0] mid_value [AXES];
  led_lane_stat_t                stat [AXES];
  led_group_t                    grp;

  assign sample_stall = full;

  always_comb begin
    accept       = sample_valid && !full;
    judge        = accept && (primed == PRIME_DONE);
    counter_next = (counter == '1) ? counter : counter + 1'b1;
    cur[0]       = sample.pos_x;
    cur[1]       = sample.pos_y;
    cur[2]       = sample.pos_z;
    grp.sample_number = counter_next;
    grp.extremum_time = prev_time;
    for (int a = 0; a < AXES; a++) begin
      grp.value[a]  = mid_value[a];
      grp.hit[a]    = stat[a].hit;
      grp.is_max[a] = stat[a].is_max;
    end
    push = judge && (grp.hit != '0);
  end

  for (genvar g = 0; g < AXES; g++) begin : g_lane
    led_lane u_lane (
      .clk       (clk),
      .rst       (rst),
      .shift     (accept),
      .judge     (judge),
      .cur       (cur[g]),
      .prev_time (prev_time),
      .step      (step),
      .stat      (stat[g]),
      .mid_value (mid_value[g])
    );
  end

  led_merge #(
    .DEPTH (GROUP_DEPTH)
  ) u_merge (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .push_group   (grp),
    .full         (full),
    .report_valid (report_valid),
    .report_stall (report_stall),
    .report       (report)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      step      <= STEP_RESET;
      prev_time <= '0;
      primed    <= '0;
      counter   <= COUNT_RESET;
    end else begin
      if (step_wr_en) begin
        step <= step_wr_data;
      end
      if (accept) begin
        prev_time <= sample.sample_time;
        if (primed != PRIME_DONE) begin
          primed <= primed + 1'b1;
        end
      end
      if (judge) begin
        counter <= counter_next;
      end
    end
  end

`ifndef SYNTHESIS
  // window not yet full: no report group may enter the queue
  a_no_push_priming: assert property (@(posedge clk) disable iff (rst)
    (primed != PRIME_DONE) |-> !push)
    else $error("report group pushed while window priming");

  // sample count advances by one per judged beat and saturates
  a_counter_step: assert property (@(posedge clk) disable iff (rst)
    judge |=> (counter == (($past(counter) == '1) ? $past(counter) : $past(counter) + 1'b1)))
    else $error("sample count did not advance correctly");

  // no report beat right out of reset
  a_reset_quiet: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !report_valid)
    else $error("report beat present after reset");

  // a full queue must hold off the sample side
  a_full_stalls: assert property (@(posedge clk) disable iff (rst)
    full |-> (sample_stall && !push))
    else $error("sample beat taken while queue full");
`endif

endmodule
